// File: design/xxh32_pkg.sv
package xxh32_pkg;

  localparam logic [31:0] K1 = 32'd2654435761;
  localparam logic [31:0] K2 = 32'd2246822519;
  localparam logic [31:0] K3 = 32'd3266489917;
  localparam logic [31:0] K4 = 32'd668265263;
  localparam logic [31:0] K5 = 32'd374761393;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;

  // One classified message item as it waits between the front and the back.
  typedef struct packed {
    logic [31:0] word;
    logic        push;    // word goes into the stripe buffer as four bytes
    logic        last;    // final item of the message
    logic [1:0]  nbytes;  // tail bytes to mix one by one (last item only)
  } item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FOLD_MUL,
    ST_FOLD_ROT,
    ST_FOLD_UPD,
    ST_MERGE,
    ST_ADD_LEN,
    ST_WORD_MUL,
    ST_WORD_ROT,
    ST_WORD_UPD,
    ST_BYTE_MUL,
    ST_BYTE_ROT,
    ST_BYTE_UPD,
    ST_AVAL1,
    ST_AVAL2,
    ST_AVAL3,
    ST_AVAL4,
    ST_OUT
  } state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

// File: design/xxhash32_stream_core.sv
// A word that does not end a stripe is stored in the stripe buffer; one that completes a
// 16-byte stripe starts a fold (four lanes, three steps each, one shared multiplier). A last
// item adds the merge, the length add, three steps per leftover word and per tail byte, and the
// avalanche. Throughput: 1 word per cycle between stripe folds and message finishes.
// Reset: synchronous, active-low rst_n; the seed returns to zero and the message is cleared.
module xxhash32_stream_core
  import xxh32_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Message item input.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0 up: data_word [31:0], valid_bytes [34:32], zero padding [39:35].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  // Hash result output.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0 up: hash_value [31:0].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Seed register write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data
);

  // The front end holds the seed register and a two-entry queue of classified
  // items. Classification decides whether the word enters the stripe buffer as
  // four bytes and how many tail bytes the last item leaves for byte mixing.
  logic [31:0] seed;
  logic        q_valid;
  logic        q_ready;
  item_t       q_item;

  xxh32_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .seed      (seed),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // The back end runs the hash sequencer around one 32x32 multiplier whose
  // result is always registered. Stripe folds, the leftover word and byte
  // rounds and the avalanche all take turns on it.
  // The finished hash sits in an output register, so the next message can be
  // started while the result still waits to be taken.
  xxh32_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: design/xxh32_front.sv
module xxh32_front
  import xxh32_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  output logic [31:0]           seed,
  output logic                  q_valid,
  input  logic                  q_ready,
  output item_t                 q_item
);

  item_t       q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [2:0]  vb;
  logic        full_word;
  item_t       cls;
  logic        do_push, do_pop;

  assign cfg_ready = 1'b1;
  assign seed      = seed_r;
  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = q_mem_r[rd_ptr_r];

  // A count of five to seven means four; it only matters on the last item.
  assign vb        = in_tdata[34:32];
  assign full_word = vb[2];

  always_comb begin
    cls.word   = in_tdata[31:0];
    cls.last   = in_tlast;
    cls.push   = !in_tlast || full_word;
    cls.nbytes = (in_tlast && !full_word) ? vb[1:0] : 2'd0;
  end

  assign do_push = in_tvalid && in_tready;
  assign do_pop  = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
    seed_nxt   = (cfg_valid && cfg_ready) ? cfg_data : seed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      seed_r   <= 32'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      seed_r   <= seed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: design/xxh32_back.sv
module xxh32_back
  import xxh32_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            seed,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  item_t                  q_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  state_t      state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [31:0] len_r, len_nxt;
  logic        seen_r, seen_nxt;
  logic        fin_r, fin_nxt;
  logic [1:0]  nb_r, nb_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] lane_r [4];
  logic [31:0] lane_nxt [4];
  logic [31:0] buf_r [4];
  logic [31:0] buf_nxt [4];
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic [31:0] mul_a, mul_k, prod;
  logic        take, slot_free;

  assign q_ready    = (state_r == ST_IDLE);
  assign take       = q_valid && q_ready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The single shared multiplier; its result is always registered.
  always_comb begin
    mul_a = x_r;
    mul_k = K1;
    case (state_r)
      ST_FOLD_MUL: begin
        mul_a = buf_r[idx_r];
        mul_k = K2;
      end
      ST_WORD_MUL: begin
        mul_a = buf_r[idx_r];
        mul_k = K3;
      end
      ST_WORD_UPD: mul_k = K4;
      ST_BYTE_MUL: begin
        mul_a = {24'd0, word_r[{idx_r, 3'b000} +: 8]};
        mul_k = K5;
      end
      ST_AVAL2: mul_k = K2;
      ST_AVAL4: mul_k = K3;
      default:  mul_k = K1;
    endcase
  end

  assign prod = mul_a * mul_k;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_item.push && fill_r == 2'd3) begin
            state_nxt = ST_FOLD_MUL;
          end else if (q_item.last) begin
            state_nxt = ST_MERGE;
          end
        end
      end
      ST_FOLD_MUL: state_nxt = ST_FOLD_ROT;
      ST_FOLD_ROT: state_nxt = ST_FOLD_UPD;
      ST_FOLD_UPD: begin
        if (idx_r == 2'd3) begin
          state_nxt = fin_r ? ST_MERGE : ST_IDLE;
        end else begin
          state_nxt = ST_FOLD_MUL;
        end
      end
      ST_MERGE: state_nxt = ST_ADD_LEN;
      ST_ADD_LEN: begin
        if (fill_r != 2'd0) begin
          state_nxt = ST_WORD_MUL;
        end else if (nb_r != 2'd0) begin
          state_nxt = ST_BYTE_MUL;
        end else begin
          state_nxt = ST_AVAL1;
        end
      end
      ST_WORD_MUL: state_nxt = ST_WORD_ROT;
      ST_WORD_ROT: state_nxt = ST_WORD_UPD;
      ST_WORD_UPD: begin
        if (idx_r + 2'd1 == fill_r) begin
          state_nxt = (nb_r != 2'd0) ? ST_BYTE_MUL : ST_AVAL1;
        end else begin
          state_nxt = ST_WORD_MUL;
        end
      end
      ST_BYTE_MUL: state_nxt = ST_BYTE_ROT;
      ST_BYTE_ROT: state_nxt = ST_BYTE_UPD;
      ST_BYTE_UPD: state_nxt = (idx_r + 2'd1 == nb_r) ? ST_AVAL1 : ST_BYTE_MUL;
      ST_AVAL1: state_nxt = ST_AVAL2;
      ST_AVAL2: state_nxt = ST_AVAL3;
      ST_AVAL3: state_nxt = ST_AVAL4;
      ST_AVAL4: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = slot_free ? ST_IDLE : ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    fin_nxt       = fin_r;
    nb_nxt        = nb_r;
    word_nxt      = word_r;
    x_nxt         = x_r;
    h_nxt         = h_r;
    lane_nxt      = lane_r;
    buf_nxt       = buf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = 2'd0;
        if (take) begin
          word_nxt = q_item.word;
          nb_nxt   = q_item.nbytes;
          fin_nxt  = q_item.last;
          if (q_item.push) begin
            buf_nxt[fill_r] = q_item.word;
            fill_nxt        = fill_r + 2'd1;
            len_nxt         = len_r + 32'd4;
            if (fill_r == 2'd3 && !seen_r) begin
              lane_nxt[0] = seed + K1 + K2;
              lane_nxt[1] = seed + K2;
              lane_nxt[2] = seed;
              lane_nxt[3] = seed - K1;
            end
          end else begin
            len_nxt = len_r + {30'd0, q_item.nbytes};
          end
        end
      end
      ST_FOLD_MUL: x_nxt = prod;
      ST_FOLD_ROT: x_nxt = rotl32(lane_r[idx_r] + x_r, 13);
      ST_FOLD_UPD: begin
        lane_nxt[idx_r] = prod;
        idx_nxt         = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          seen_nxt = 1'b1;
        end
      end
      ST_MERGE: begin
        if (seen_r) begin
          h_nxt = rotl32(lane_r[0], 1) + rotl32(lane_r[1], 7)
                + rotl32(lane_r[2], 12) + rotl32(lane_r[3], 18);
        end else begin
          h_nxt = seed + K5;
        end
      end
      ST_ADD_LEN: begin
        h_nxt   = h_r + len_r;
        idx_nxt = 2'd0;
      end
      ST_WORD_MUL: x_nxt = prod;
      ST_WORD_ROT: x_nxt = rotl32(h_r + x_r, 17);
      ST_WORD_UPD: begin
        h_nxt   = prod;
        idx_nxt = (idx_r + 2'd1 == fill_r) ? 2'd0 : idx_r + 2'd1;
      end
      ST_BYTE_MUL: x_nxt = prod;
      ST_BYTE_ROT: x_nxt = rotl32(h_r + x_r, 11);
      ST_BYTE_UPD: begin
        h_nxt   = prod;
        idx_nxt = idx_r + 2'd1;
      end
      ST_AVAL1: x_nxt = h_r ^ (h_r >> 15);
      ST_AVAL2: h_nxt = prod;
      ST_AVAL3: x_nxt = h_r ^ (h_r >> 13);
      ST_AVAL4: h_nxt = prod;
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = h_r ^ (h_r >> 16);
          fill_nxt      = 2'd0;
          len_nxt       = 32'd0;
          seen_nxt      = 1'b0;
          fin_nxt       = 1'b0;
        end
      end
      default: idx_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 2'd0;
      fill_r      <= 2'd0;
      len_r       <= 32'd0;
      seen_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nb_r       <= nb_nxt;
    word_r     <= word_nxt;
    x_r        <= x_nxt;
    h_r        <= h_nxt;
    lane_r     <= lane_nxt;
    buf_r      <= buf_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: design/xxh32_checker.sv
module xxh32_checker
  import xxh32_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No result is pending right after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The input queue only fills up when an item has just been taken.
  a_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("input stalled without a new item");

  // The seed register always takes a write once out of reset.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("seed write refused");

endmodule

bind xxhash32_stream_core xxh32_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// File: test/xxhash32_hash_checker.sv
module xxhash32_hash_checker
  import xxh32_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // Fields from bit 0 up: data_word [31:0], valid_bytes [34:32], zero padding.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0 up: hash_value [31:0].
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [31:0]            cfg_data,
  output int                     hashes_owed,
  output int                     mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] PRIME1 = 32'h9E3779B1;
  localparam logic [31:0] PRIME2 = 32'h85EBCA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
  localparam logic [31:0] PRIME5 = 32'h165667B1;

  logic [31:0] seed_reg;
  logic [31:0] lane [4];
  logic [31:0] stripe [4];
  int unsigned stripe_words;
  logic [31:0] msg_bytes;
  bit          lanes_live;
  logic [31:0] hashes_due [$];

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic clear_message();
    stripe_words = 0;
    msg_bytes    = '0;
    lanes_live   = 1'b0;
  endtask

  // Lanes pick up the seed only when the first stripe of a message is folded.
  task automatic take_word(input logic [31:0] w);
    stripe[stripe_words] = w;
    stripe_words++;
    msg_bytes += 32'd4;
    if (stripe_words == 4) begin
      if (!lanes_live) begin
        lane[0] = seed_reg + PRIME1 + PRIME2;
        lane[1] = seed_reg + PRIME2;
        lane[2] = seed_reg;
        lane[3] = seed_reg - PRIME1;
      end
      for (int i = 0; i < 4; i++) begin
        lane[i] = rol32(lane[i] + stripe[i] * PRIME2, 13) * PRIME1;
      end
      stripe_words = 0;
      lanes_live   = 1'b1;
    end
  endtask

  task automatic close_message(input logic [31:0] w, input logic [2:0] nb);
    logic [31:0] h;
    logic [31:0] b;
    int unsigned tail;
    tail = (nb > 3'd4) ? 4 : nb;
    if (tail == 4) begin
      take_word(w);
      tail = 0;
    end else begin
      msg_bytes += tail;
    end
    if (lanes_live) begin
      h = rol32(lane[0], 1) + rol32(lane[1], 7) + rol32(lane[2], 12) + rol32(lane[3], 18);
    end else begin
      h = seed_reg + PRIME5;
    end
    h += msg_bytes;
    for (int i = 0; i < stripe_words; i++) begin
      h += stripe[i] * PRIME3;
      h = rol32(h, 17) * PRIME4;
    end
    for (int i = 0; i < tail; i++) begin
      b = {24'd0, w[8*i +: 8]};
      h += b * PRIME5;
      h = rol32(h, 11) * PRIME1;
    end
    h ^= h >> 15;
    h *= PRIME2;
    h ^= h >> 13;
    h *= PRIME3;
    h ^= h >> 16;
    hashes_due.push_back(h);
    clear_message();
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      seed_reg = '0;
      clear_message();
      hashes_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (hashes_due.size() == 0) begin
          mismatches++;
          $error("hash_value: unexpected result, expected none, actual %08h",
                 out_tdata[31:0]);
        end else begin
          want = hashes_due.pop_front();
          if (out_tdata[31:0] !== want) begin
            mismatches++;
            $error("hash_value mismatch: expected %08h, actual %08h", want, out_tdata[31:0]);
          end
        end
      end
      if (cfg_valid && cfg_ready) seed_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tlast) close_message(in_tdata[31:0], in_tdata[34:32]);
        else take_word(in_tdata[31:0]);
      end
    end
    hashes_owed <= hashes_due.size();
  end

endmodule

// File: test/xxhash32_stream_core_tb.sv
module xxhash32_stream_core_tb
  import xxh32_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let a folding stripe or a finishing hash settle before the seed is
  // rewritten.
  localparam int SETTLE_CYCLES  = 48;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 250;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // Fields from bit 0 up: data_word [31:0], valid_bytes [34:32], zero padding [39:35].
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  // Fields from bit 0 up: hash_value [31:0].
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [31:0]            cfg_data;

  int hashes_owed;
  int mismatches;

  // Idle rates in percent for the sender and the receiver, set per phase.
  int gap_pct;
  int stall_pct;
  // The stimulus asks for a long hold-off by bumping holds_asked; the receiver
  // process counts the stretch out on its own.
  int holds_asked;
  int holds_served;
  int hold_left;

  always #4 clk = ~clk;

  xxhash32_stream_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  xxhash32_hash_checker hash_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .hashes_owed (hashes_owed),
    .mismatches  (mismatches)
  );

  // Result side: random back-pressure, overridden by a requested long hold-off.
  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left    <= LONG_HOLD;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one item and returns at the edge where it is taken. The valid stays
  // high afterwards, so back-to-back items need no extra assignment to it.
  task automatic send_item(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic lst);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, nbytes, word};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering items until every hash that is owed has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (hashes_owed != 0);
  endtask

  // The seed is only rewritten with the block at rest; a word that completed a
  // stripe gives no result, so a fixed settle time follows the drain.
  task automatic load_seed(input logic [31:0] s);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A message of random content. Most are short, a few run over several stripes.
  // The byte count of non-final words is random too, since the block ignores it.
  task automatic send_message(output int unsigned count);
    int unsigned words;
    words = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
    for (int i = 0; i < words; i++) send_item($urandom, 3'($urandom_range(7)), 1'b0);
    send_item($urandom, 3'($urandom_range(7)), 1'b1);
    count = words + 1;
  endtask

  initial begin
    int unsigned sent;
    int unsigned msg_items;
    bit          paused;
    logic [31:0] phase_seed;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    holds_asked  = 0;
    holds_served = 0;
    hold_left    = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, seed still at its reset value of zero.
    // Empty message, then messages of one to four bytes.
    send_item(32'h00000000, 3'd0, 1'b1);
    send_item(32'hFFFFFFFF, 3'd1, 1'b1);
    send_item(32'h0000A55A, 3'd2, 1'b1);
    send_item(32'h80000001, 3'd3, 1'b1);
    send_item(32'hFFFFFFFF, 3'd4, 1'b1);
    // Byte counts of five to seven on a last item behave like four.
    send_item(32'h12345678, 3'd5, 1'b1);
    send_item(32'h9ABCDEF0, 3'd6, 1'b1);
    send_item(32'hFFFFFFFF, 3'd7, 1'b1);

    // Top seed. A full stripe whose words carry junk byte counts, then a tail.
    load_seed(32'hFFFFFFFF);
    send_item(32'h00000000, 3'd7, 1'b0);
    send_item(32'hFFFFFFFF, 3'd0, 1'b0);
    send_item(32'h80000000, 3'd3, 1'b0);
    send_item(32'h00000001, 3'd5, 1'b0);
    send_item(32'hC0FFEE11, 3'd3, 1'b1);
    // The last item itself completes the stripe, so nothing is left over.
    send_item(32'h01234567, 3'd2, 1'b0);
    send_item(32'h89ABCDEF, 3'd6, 1'b0);
    send_item(32'hFEDCBA98, 3'd1, 1'b0);
    send_item(32'h76543210, 3'd4, 1'b1);

    // Seed changed in the middle of a message: the first fold must use the new one.
    send_item(32'hDEADBEEF, 3'd4, 1'b0);
    send_item(32'h0BADF00D, 3'd4, 1'b0);
    load_seed(32'h9E3779B9);
    send_item(32'h55555555, 3'd0, 1'b0);
    send_item(32'hAAAAAAAA, 3'd0, 1'b0);
    // Last item with no bytes right after a fold.
    send_item(32'h13579BDF, 3'd0, 1'b1);
    // Seed changed in a message too short to fold: the tail uses the new seed.
    send_item(32'h2468ACE0, 3'd4, 1'b0);
    load_seed(32'h00000000);
    send_item(32'hF0E1D2C3, 3'd3, 1'b1);

    // Random part in four phases: no idling, a slow sender, a slow receiver,
    // then both. Each phase starts with a fresh seed, the extremes among them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: phase_seed = 32'h00000000;
        2: phase_seed = 32'hFFFFFFFF;
        default: phase_seed = $urandom;
      endcase
      load_seed(phase_seed);
      gap_pct   <= (ph == 1 || ph == 3) ? ((ph == 1) ? 45 : 21) : 0;
      stall_pct <= (ph == 2 || ph == 3) ? ((ph == 2) ? 45 : 21) : 0;
      // In the phase without idling the receiver goes quiet for a long time
      // while the sender keeps offering, so the block has to stall its input.
      if (ph == 0) holds_asked <= holds_asked + 1;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        send_message(msg_items);
        sent += msg_items;
        // Halfway through the slow-sender phase the sender waits for the
        // block to empty completely before going on.
        if (ph == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a block that hangs; a correct run ends far earlier.
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
design/xxh32_pkg.sv
design/xxh32_front.sv
design/xxh32_back.sv
design/xxhash32_stream_core.sv
design/xxh32_checker.sv
test/xxhash32_hash_checker.sv
test/xxhash32_stream_core_tb.sv
